/* rtl/windowed_vector_autocorrelation_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the windowed vector autocorrelation block
// Short forms for clocked checks on clk with asynchronous reset arst_n.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_VECTOR_AUTOCORRELATION_MACROS_SVH
`define WINDOWED_VECTOR_AUTOCORRELATION_MACROS_SVH

// check that cons holds in the same cycle as ante
`define WVAC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check that cons holds in the cycle after ante
`define WVAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/wvac_pkg.sv */
// ----------------------------------------------------------------------------
// wvac_pkg
// Shared widths, register indexes and types of the vector autocorrelator.
// ----------------------------------------------------------------------------
`default_nettype none

package wvac_pkg;

	localparam int MAX_LAG   = 64;
	localparam int LAG_W     = $clog2(MAX_LAG);
	localparam int LEN_W     = 7;
	localparam int CNT_W     = 16;
	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int CMP_W     = 24;
	localparam int UNIT_W    = 18;
	localparam int QUO_W     = 17;
	localparam int PROD_W    = 2 * UNIT_W;
	localparam int SUM_W     = 42;
	localparam int ACC_W     = 48;
	localparam int DIV_NUM_W = 48;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
	localparam int IDX_W     = 2;
	localparam int DATA_W    = 16;

	localparam logic [IDX_W-1:0] REG_WINDOW_LEN   = 2'd0;
	localparam logic [IDX_W-1:0] REG_WINDOW_COUNT = 2'd1;

	localparam logic [LEN_W-1:0] WINDOW_LEN_RST   = 7'd64;
	localparam logic [CNT_W-1:0] WINDOW_COUNT_RST = 16'd1;

	typedef struct packed {
		logic signed [UNIT_W-1:0] x;
		logic signed [UNIT_W-1:0] y;
		logic signed [UNIT_W-1:0] z;
	} unit_vec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quot;
	} div_rsp_t;

	// window length in use: zero acts as one, above the store depth as the depth
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] r;
		r = len;
		if (len == '0)
			r = LEN_W'(1);
		else if (len > LEN_W'(MAX_LAG))
			r = LEN_W'(MAX_LAG);
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/windowed_vector_autocorrelation.sv */
// The normalizer holds busy high from taking a frame until it pushes the result.
// It takes a new frame only when idle; its work is a 32-step root and 3 x 17-step divide.
// At a window end the correlator runs a lag pass over every lag below the window length.
// In a result run each lag waits for one division of the shared 48-step divider.
// Reset clears control state and all lag accumulator valid flags; results cannot be stalled.
// ----------------------------------------------------------------------------
// windowed_vector_autocorrelation
// Top level: configuration registers, normalizer, queue, correlator, divider.
// ----------------------------------------------------------------------------
`default_nettype none

`include "windowed_vector_autocorrelation_macros.svh"

module windowed_vector_autocorrelation (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [wvac_pkg::COORD_W-1:0] first_x,
	input  wire logic signed [wvac_pkg::COORD_W-1:0] first_y,
	input  wire logic signed [wvac_pkg::COORD_W-1:0] first_z,
	input  wire logic signed [wvac_pkg::COORD_W-1:0] second_x,
	input  wire logic signed [wvac_pkg::COORD_W-1:0] second_y,
	input  wire logic signed [wvac_pkg::COORD_W-1:0] second_z,
	input  wire logic                                wr_en,
	input  wire logic [wvac_pkg::IDX_W-1:0]          wr_index,
	input  wire logic [wvac_pkg::DATA_W-1:0]         wr_data,
	output logic                                     result_valid,
	output logic [wvac_pkg::LAG_W-1:0]               lag,
	output logic signed [31:0]                       correlation,
	output logic                                     last
);

	logic [wvac_pkg::LEN_W-1:0] window_len_q;
	logic [wvac_pkg::CNT_W-1:0] window_count_q;

	logic                 push;
	logic                 pop;
	wvac_pkg::unit_vec_t  push_data;
	wvac_pkg::unit_vec_t  pop_data;
	wvac_pkg::fifo_stat_t q_stat;
	wvac_pkg::div_req_t   div_req;
	wvac_pkg::div_rsp_t   div_rsp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q   <= wvac_pkg::WINDOW_LEN_RST;
			window_count_q <= wvac_pkg::WINDOW_COUNT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				wvac_pkg::REG_WINDOW_LEN:   window_len_q   <= wr_data[wvac_pkg::LEN_W-1:0];
				wvac_pkg::REG_WINDOW_COUNT: window_count_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	wvac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.first_x   (first_x),
		.first_y   (first_y),
		.first_z   (first_z),
		.second_x  (second_x),
		.second_y  (second_y),
		.second_z  (second_z),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	wvac_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	wvac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	wvac_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.window_len   (window_len_q),
		.window_count (window_count_q),
		.q_stat       (q_stat),
		.pop_data     (pop_data),
		.pop          (pop),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.result_valid (result_valid),
		.lag          (lag),
		.correlation  (correlation),
		.last         (last)
	);

	`WVAC_ASSERT_SAME(a_no_push_full, push, !q_stat.full, "item pushed into a full queue")
	`WVAC_ASSERT_SAME(a_corr_range, result_valid, (correlation <= 32'sh4000_0000) && (correlation >= -32'sh4000_0000), "correlation outside unit range")
	`WVAC_ASSERT_NEXT(a_result_gap, result_valid, !result_valid, "results closer than the divider allows")

endmodule

`default_nettype wire

/* rtl/wvac_front.sv */
// ----------------------------------------------------------------------------
// wvac_front
// Takes a frame, forms the difference vector and normalizes it to a unit
// vector with one multiplier, a bit-pair square root and a restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module wvac_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [wvac_pkg::COORD_W-1:0] first_x,
	input  wire logic signed [wvac_pkg::COORD_W-1:0] first_y,
	input  wire logic signed [wvac_pkg::COORD_W-1:0] first_z,
	input  wire logic signed [wvac_pkg::COORD_W-1:0] second_x,
	input  wire logic signed [wvac_pkg::COORD_W-1:0] second_y,
	input  wire logic signed [wvac_pkg::COORD_W-1:0] second_z,
	input  wire wvac_pkg::fifo_stat_t                q_stat,
	output logic                                     push,
	output wvac_pkg::unit_vec_t                      push_data
);

	typedef enum logic [6:0] {
		F_IDLE  = 7'b0000001,
		F_PREP  = 7'b0000010,
		F_SQ    = 7'b0000100,
		F_SQRT  = 7'b0001000,
		F_DLOAD = 7'b0010000,
		F_DIV   = 7'b0100000,
		F_PUSH  = 7'b1000000
	} front_state_t;

	localparam int SQ_W   = 2 * wvac_pkg::CMP_W + 2;
	localparam int ROOT_W = SQ_W + 13;
	localparam int REM_W  = 48;

	front_state_t state_q;

	logic signed [wvac_pkg::DIFF_W-1:0] d_q [3];
	logic [wvac_pkg::CMP_W-1:0]         c_q [3];
	logic signed [wvac_pkg::UNIT_W-1:0] u_q [3];
	logic [1:0]                         comp_q;
	logic [SQ_W-1:0]                    s_q;
	logic [ROOT_W-1:0]                  n_q;
	logic [ROOT_W-1:0]                  r_q;
	logic [ROOT_W-1:0]                  bit_q;
	logic [4:0]                         step_q;
	logic [REM_W-1:0]                   rem_q;
	logic [REM_W-1:0]                   dv_q;
	logic [wvac_pkg::QUO_W-1:0]         quo_q;

	logic [wvac_pkg::DIFF_W-1:0]        mag [3];
	logic [wvac_pkg::DIFF_W-1:0]        m;
	logic [3:0]                         sh;
	logic [2*wvac_pkg::CMP_W-1:0]       sq_prod;
	logic [SQ_W-1:0]                    sq_next;
	logic [ROOT_W:0]                    root_t;
	logic                               root_ge;
	logic                               div_ge;
	logic [wvac_pkg::QUO_W-1:0]         quo_next;

	// magnitudes, largest component and the shift that fits it in 24 bits
	always_comb begin
		m = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = d_q[i][wvac_pkg::DIFF_W-1] ? wvac_pkg::DIFF_W'(-d_q[i])
				: wvac_pkg::DIFF_W'(d_q[i]);
			if (mag[i] > m)
				m = mag[i];
		end
		sh = 4'd9;
		for (int k = 8; k >= 0; k--) begin
			if ((m >> k) < wvac_pkg::DIFF_W'(1 << wvac_pkg::CMP_W))
				sh = k[3:0];
		end
	end

	assign sq_prod  = c_q[comp_q] * c_q[comp_q];
	assign sq_next  = s_q + SQ_W'(sq_prod);
	assign root_t   = {1'b0, r_q} + {1'b0, bit_q};
	assign root_ge  = {1'b0, n_q} >= root_t;
	assign div_ge   = rem_q >= dv_q;
	assign quo_next = {quo_q[wvac_pkg::QUO_W-2:0], div_ge};

	assign busy      = state_q != F_IDLE;
	assign push      = (state_q == F_PUSH) && !q_stat.full;
	assign push_data = '{x: u_q[0], y: u_q[1], z: u_q[2]};

	// sequence one frame through the shared arithmetic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE:  if (start) state_q <= F_PREP;
				F_PREP:  state_q <= (m == '0) ? F_PUSH : F_SQ;
				F_SQ:    if (comp_q == 2'd2) state_q <= F_SQRT;
				F_SQRT:  if (step_q == 5'd31) state_q <= F_DLOAD;
				F_DLOAD: state_q <= F_DIV;
				F_DIV:   if (step_q == 5'd0) state_q <= (comp_q == 2'd2) ? F_PUSH : F_DLOAD;
				F_PUSH:  if (!q_stat.full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				d_q[0] <= wvac_pkg::DIFF_W'(second_x) - wvac_pkg::DIFF_W'(first_x);
				d_q[1] <= wvac_pkg::DIFF_W'(second_y) - wvac_pkg::DIFF_W'(first_y);
				d_q[2] <= wvac_pkg::DIFF_W'(second_z) - wvac_pkg::DIFF_W'(first_z);
			end
			F_PREP: begin
				for (int i = 0; i < 3; i++) begin
					c_q[i] <= wvac_pkg::CMP_W'(mag[i] >> sh);
					u_q[i] <= '0;
				end
				s_q    <= '0;
				comp_q <= 2'd0;
			end
			F_SQ: begin
				s_q <= sq_next;
				if (comp_q == 2'd2) begin
					n_q    <= {1'b0, sq_next, 12'b0};
					r_q    <= '0;
					bit_q  <= ROOT_W'(1) << (ROOT_W - 1);
					step_q <= 5'd0;
					comp_q <= 2'd0;
				end else begin
					comp_q <= comp_q + 2'd1;
				end
			end
			F_SQRT: begin
				if (root_ge) begin
					n_q <= n_q - root_t[ROOT_W-1:0];
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q  <= bit_q >> 2;
				step_q <= step_q + 5'd1;
			end
			F_DLOAD: begin
				rem_q  <= REM_W'({c_q[comp_q], 22'b0}) + REM_W'(r_q[31:1]);
				dv_q   <= REM_W'({r_q[31:0], 16'b0});
				quo_q  <= '0;
				step_q <= 5'd16;
			end
			F_DIV: begin
				if (div_ge)
					rem_q <= rem_q - dv_q;
				dv_q  <= dv_q >> 1;
				quo_q <= quo_next;
				step_q <= step_q - 5'd1;
				if (step_q == 5'd0) begin
					u_q[comp_q] <= d_q[comp_q][wvac_pkg::DIFF_W-1]
						? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
					comp_q <= comp_q + 2'd1;
				end
			end
			F_PUSH: begin
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/wvac_fifo.sv */
// ----------------------------------------------------------------------------
// wvac_fifo
// Two-entry queue of unit vectors between the normalizer and the correlator.
// ----------------------------------------------------------------------------
`default_nettype none

module wvac_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire wvac_pkg::unit_vec_t push_data,
	input  wire logic                pop,
	output wvac_pkg::unit_vec_t      pop_data,
	output wvac_pkg::fifo_stat_t     stat
);

	wvac_pkg::unit_vec_t entry_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          count_q;

	assign pop_data   = entry_q[rd_ptr_q];
	assign stat.full  = count_q == 2'd2;
	assign stat.empty = count_q == 2'd0;

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// hold entries
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

/* rtl/wvac_div.sv */
// ----------------------------------------------------------------------------
// wvac_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wvac_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire wvac_pkg::div_req_t req,
	output wvac_pkg::div_rsp_t      rsp
);

	logic                               busy_q;
	logic                               done_q;
	logic [wvac_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [wvac_pkg::DIV_DEN_W-1:0]     rem_q;
	logic [wvac_pkg::DIV_DEN_W-1:0]     den_q;
	logic [wvac_pkg::DIV_NUM_W-1:0]     nq_q;

	logic [wvac_pkg::DIV_DEN_W:0]       trial;
	logic                               ge;

	assign trial = {rem_q, nq_q[wvac_pkg::DIV_NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	assign rsp.done = done_q;
	assign rsp.quot = nq_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == wvac_pkg::DIV_CNT_W'(wvac_pkg::DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift numerator out and quotient in
	always_ff @(posedge clk) begin
		if (req.start) begin
			nq_q  <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? wvac_pkg::DIV_DEN_W'(trial - {1'b0, den_q})
				: wvac_pkg::DIV_DEN_W'(trial);
			nq_q  <= {nq_q[wvac_pkg::DIV_NUM_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

/* rtl/wvac_back.sv */
// ----------------------------------------------------------------------------
// wvac_back
// Stores unit vectors of a window, forms per-lag mean dot products through a
// read/multiply/accumulate pipeline, keeps the lag accumulators and emits
// the averaged run.
// ----------------------------------------------------------------------------
`default_nettype none

module wvac_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [wvac_pkg::LEN_W-1:0]        window_len,
	input  wire logic [wvac_pkg::CNT_W-1:0]        window_count,
	input  wire wvac_pkg::fifo_stat_t              q_stat,
	input  wire wvac_pkg::unit_vec_t               pop_data,
	output logic                                   pop,
	output wvac_pkg::div_req_t                     div_req,
	input  wire wvac_pkg::div_rsp_t                div_rsp,
	output logic                                   result_valid,
	output logic [wvac_pkg::LAG_W-1:0]             lag,
	output logic signed [31:0]                     correlation,
	output logic                                   last
);

	typedef enum logic [7:0] {
		B_IDLE    = 8'b00000001,
		B_PAIRS   = 8'b00000010,
		B_DRAIN   = 8'b00000100,
		B_MEAN    = 8'b00001000,
		B_MEANW   = 8'b00010000,
		B_OUTRD   = 8'b00100000,
		B_OUTDIV  = 8'b01000000,
		B_OUTW    = 8'b10000000
	} back_state_t;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	back_state_t state_q;

	wvac_pkg::unit_vec_t               store_mem [wvac_pkg::MAX_LAG];
	logic signed [wvac_pkg::ACC_W-1:0] acc_mem   [wvac_pkg::MAX_LAG];
	logic [wvac_pkg::MAX_LAG-1:0]      acc_valid_q;

	logic [wvac_pkg::LAG_W-1:0]        fp_q;
	logic [wvac_pkg::CNT_W-1:0]        wd_q;
	logic [wvac_pkg::LAG_W-1:0]        tau_q;
	logic [wvac_pkg::LAG_W-1:0]        j_q;
	logic signed [wvac_pkg::SUM_W-1:0] sum_q;

	wvac_pkg::unit_vec_t               sa_s1;
	wvac_pkg::unit_vec_t               sb_s1;
	logic                              vld_s1;
	logic                              last_s1;
	logic signed [wvac_pkg::PROD_W-1:0] px_s2;
	logic signed [wvac_pkg::PROD_W-1:0] py_s2;
	logic signed [wvac_pkg::PROD_W-1:0] pz_s2;
	logic                              vld_s2;
	logic                              last_s2;

	logic signed [wvac_pkg::ACC_W-1:0] acc_rd_q;
	logic                              acc_v_rd_q;

	logic                              result_valid_q;
	logic [wvac_pkg::LAG_W-1:0]        lag_q;
	logic signed [31:0]                corr_q;
	logic                              last_q;

	logic [wvac_pkg::LEN_W-1:0]        len;
	logic [wvac_pkg::CNT_W-1:0]        cnt;
	logic [wvac_pkg::LEN_W-1:0]        k;
	logic [wvac_pkg::LAG_W-1:0]        addr_b;
	logic                              issue;
	logic                              issue_last;
	logic                              sum_neg;
	logic [wvac_pkg::SUM_W-1:0]        sum_mag;
	logic signed [wvac_pkg::ACC_W-1:0] acc_base;
	logic [wvac_pkg::ACC_W-1:0]        acc_mag;
	logic signed [wvac_pkg::ACC_W-1:0] mean_q30;
	logic [wvac_pkg::DIV_NUM_W-1:0]    out_mag;
	logic [30:0]                       out_clamp;
	logic                              lag_last;
	logic [wvac_pkg::CNT_W-1:0]        wd_next;

	assign len        = wvac_pkg::eff_len(window_len);
	assign cnt        = (window_count == '0) ? wvac_pkg::CNT_W'(1) : window_count;
	assign k          = len - {1'b0, tau_q};
	assign addr_b     = j_q + tau_q;
	assign issue      = state_q == B_PAIRS;
	assign issue_last = ({1'b0, j_q} + {1'b0, tau_q}) == (len - 1'b1);
	assign lag_last   = ({1'b0, tau_q} + 1'b1) >= len;
	assign wd_next    = wd_q + 1'b1;

	assign sum_neg  = sum_q[wvac_pkg::SUM_W-1];
	assign sum_mag  = sum_neg ? wvac_pkg::SUM_W'(-sum_q) : wvac_pkg::SUM_W'(sum_q);
	assign acc_base = acc_v_rd_q ? acc_rd_q : '0;
	assign acc_mag  = acc_base[wvac_pkg::ACC_W-1] ? wvac_pkg::ACC_W'(-acc_base)
		: wvac_pkg::ACC_W'(acc_base);

	// window mean: quotient by (L - tau), then by four
	assign mean_q30 = sum_neg
		? -$signed(wvac_pkg::ACC_W'(div_rsp.quot >> 2))
		: $signed(wvac_pkg::ACC_W'(div_rsp.quot >> 2));

	assign out_mag   = div_rsp.quot;
	assign out_clamp = (out_mag > wvac_pkg::DIV_NUM_W'(ONE_Q30)) ? ONE_Q30 : out_mag[30:0];

	// feed the shared divider
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		unique case (state_q)
			B_MEAN: begin
				div_req.start = 1'b1;
				div_req.num   = wvac_pkg::DIV_NUM_W'(sum_mag)
					+ wvac_pkg::DIV_NUM_W'({k, 1'b0});
				div_req.den   = wvac_pkg::DIV_DEN_W'(k);
			end
			B_OUTDIV: begin
				div_req.start = 1'b1;
				div_req.num   = acc_mag + wvac_pkg::DIV_NUM_W'(wd_q >> 1);
				div_req.den   = wd_q;
			end
			default: begin
			end
		endcase
	end

	assign pop = (state_q == B_IDLE) && !q_stat.empty;

	assign result_valid = result_valid_q;
	assign lag          = lag_q;
	assign correlation  = corr_q;
	assign last         = last_q;

	// store memory: write on pop, two registered reads for a pair
	always_ff @(posedge clk) begin
		if (pop)
			store_mem[fp_q] <= pop_data;
		sa_s1 <= store_mem[j_q];
		sb_s1 <= store_mem[addr_b];
	end

	// lag accumulators: one write, one registered read at the current lag
	always_ff @(posedge clk) begin
		if (state_q == B_MEANW && div_rsp.done)
			acc_mem[tau_q] <= acc_base + mean_q30;
		acc_rd_q   <= acc_mem[tau_q];
		acc_v_rd_q <= acc_valid_q[tau_q];
	end

	// multiply stage
	always_ff @(posedge clk) begin
		px_s2 <= sa_s1.x * sb_s1.x;
		py_s2 <= sa_s1.y * sb_s1.y;
		pz_s2 <= sa_s1.z * sb_s1.z;
		last_s2 <= last_s1;
		last_s1 <= issue_last;
	end

	// control, pipeline valids and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= B_IDLE;
			acc_valid_q    <= '0;
			fp_q           <= '0;
			wd_q           <= '0;
			tau_q          <= '0;
			j_q            <= '0;
			sum_q          <= '0;
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			result_valid_q <= 1'b0;
			lag_q          <= '0;
			corr_q         <= '0;
			last_q         <= 1'b0;
		end else begin
			vld_s1         <= issue;
			vld_s2         <= vld_s1;
			result_valid_q <= 1'b0;
			if (vld_s2)
				sum_q <= sum_q + wvac_pkg::SUM_W'(px_s2) + wvac_pkg::SUM_W'(py_s2)
					+ wvac_pkg::SUM_W'(pz_s2);
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (({1'b0, fp_q} + 1'b1) < len) begin
							fp_q <= fp_q + 1'b1;
						end else begin
							fp_q    <= '0;
							tau_q   <= '0;
							j_q     <= '0;
							sum_q   <= '0;
							state_q <= B_PAIRS;
						end
					end
				end
				B_PAIRS: begin
					if (issue_last)
						state_q <= B_DRAIN;
					else
						j_q <= j_q + 1'b1;
				end
				B_DRAIN: begin
					if (vld_s2 && last_s2)
						state_q <= B_MEAN;
				end
				B_MEAN: begin
					state_q <= B_MEANW;
				end
				B_MEANW: begin
					if (div_rsp.done) begin
						acc_valid_q[tau_q] <= 1'b1;
						if (!lag_last) begin
							tau_q   <= tau_q + 1'b1;
							j_q     <= '0;
							sum_q   <= '0;
							state_q <= B_PAIRS;
						end else begin
							wd_q <= wd_next;
							if (wd_next >= cnt) begin
								tau_q   <= '0;
								state_q <= B_OUTRD;
							end else begin
								state_q <= B_IDLE;
							end
						end
					end
				end
				B_OUTRD: begin
					state_q <= B_OUTDIV;
				end
				B_OUTDIV: begin
					state_q <= B_OUTW;
				end
				B_OUTW: begin
					if (div_rsp.done) begin
						result_valid_q <= 1'b1;
						lag_q          <= tau_q;
						corr_q         <= acc_base[wvac_pkg::ACC_W-1]
							? -$signed({1'b0, out_clamp}) : $signed({1'b0, out_clamp});
						last_q         <= lag_last;
						if (lag_last) begin
							acc_valid_q <= '0;
							wd_q        <= '0;
							state_q     <= B_IDLE;
						end else begin
							tau_q   <= tau_q + 1'b1;
							state_q <= B_OUTRD;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
